FILE: rtl/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared constants and types of the bound step ratio test block.
// ----------------------------------------------------------------------------
package bsr_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int Q_W         = 32;
    // Exact difference bound - position.
    localparam int DIFF_W      = Q_W + 1;
    // Dividend is |difference| shifted up by the fraction bits.
    localparam int NUM_W       = DIFF_W + FRAC_BITS;
    localparam int DIV_CNT_W   = $clog2(NUM_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    // One classified element waiting for the divider.
    typedef struct packed {
        logic signed [DIFF_W-1:0] diff;
        logic signed [Q_W-1:0]    dir;
        logic                     skip;
        logic                     last;
    } t_job;

endpackage

FILE: rtl/bsr_front.sv
// ----------------------------------------------------------------------------
// bsr_front
// Input stage: picks the bound by direction sign, forms the exact
// difference and flags zero directions.
// ----------------------------------------------------------------------------
module bsr_front
    import bsr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [Q_W-1:0] i_position,
    input  logic signed [Q_W-1:0] i_lower_bound,
    input  logic signed [Q_W-1:0] i_upper_bound,
    input  logic signed [Q_W-1:0] i_step_dir,
    input  logic                  i_last,
    output logic                  o_job_valid,
    input  logic                  i_job_ready,
    output t_job                  o_job
);

    logic                  r_vld;
    logic                  n_vld;
    t_job                  r_job;
    t_job                  n_job;
    logic signed [Q_W-1:0] sel_bound;

    assign o_ready     = !r_vld || i_job_ready;
    assign o_job_valid = r_vld;
    assign o_job       = r_job;

    // A negative direction runs toward the lower bound.
    assign sel_bound = i_step_dir[Q_W-1] ? i_lower_bound : i_upper_bound;

    always_comb begin
        n_vld = r_vld;
        n_job = r_job;
        if (r_vld && i_job_ready) begin
            n_vld = 1'b0;
        end
        if (i_valid && o_ready) begin
            n_vld      = 1'b1;
            n_job.diff = DIFF_W'(sel_bound) - DIFF_W'(i_position);
            n_job.dir  = i_step_dir;
            n_job.skip = (i_step_dir == '0);
            n_job.last = i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_job <= n_job;
    end

endmodule

FILE: rtl/bsr_queue.sv
// ----------------------------------------------------------------------------
// bsr_queue
// Short register queue between the input stage and the divider back end.
// ----------------------------------------------------------------------------
module bsr_queue
    import bsr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

FILE: rtl/bsr_div.sv
// ----------------------------------------------------------------------------
// bsr_div
// Restoring divider, one quotient bit per cycle, with sign and saturation
// applied to the finished quotient.
// ----------------------------------------------------------------------------
module bsr_div
    import bsr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DIFF_W-1:0] i_diff,
    input  logic signed [Q_W-1:0]    i_dir,
    output logic                     o_done,
    output logic signed [Q_W-1:0]    o_quot
);

    logic [Q_W-1:0]       r_rem;
    logic [NUM_W-1:0]     r_quo;
    logic [Q_W-1:0]       r_dmag;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIFF_W-1:0]    nmag;
    logic [Q_W-1:0]       dmag;
    logic [Q_W:0]         rem_sh;
    logic [Q_W:0]         rem_sub;
    logic                 ge;
    logic                 big;

    // The magnitude of the most negative value still fits as unsigned.
    assign nmag = i_diff[DIFF_W-1] ? DIFF_W'(-i_diff) : DIFF_W'(i_diff);
    assign dmag = i_dir[Q_W-1] ? Q_W'(-i_dir) : Q_W'(i_dir);

    assign rem_sh  = {r_rem, r_quo[NUM_W-1]};
    assign ge      = (rem_sh >= {1'b0, r_dmag});
    assign rem_sub = rem_sh - {1'b0, r_dmag};

    // Any quotient bit at or above the sign position means out of range.
    assign big = |r_quo[NUM_W-1:Q_W-1];

    always_comb begin
        if (big) begin
            o_quot = r_neg ? Q_MIN : Q_MAX;
        end else if (r_neg) begin
            o_quot = -$signed(r_quo[Q_W-1:0]);
        end else begin
            o_quot = $signed(r_quo[Q_W-1:0]);
        end
    end

    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
        if (i_start) begin
            r_rem  <= '0;
            r_quo  <= {nmag, {FRAC_BITS{1'b0}}};
            r_dmag <= dmag;
            r_neg  <= i_diff[DIFF_W-1] ^ i_dir[Q_W-1];
            r_cnt  <= DIV_CNT_W'(NUM_W-1);
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[Q_W-1:0] : rem_sh[Q_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

FILE: rtl/bsr_back.sv
// ----------------------------------------------------------------------------
// bsr_back
// Back end: takes jobs from the queue, runs the divider and folds each
// ratio into the running least, positive-phase least and greatest values.
// ----------------------------------------------------------------------------
module bsr_back
    import bsr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  t_job                  i_job,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [Q_W-1:0] o_bound_min,
    output logic signed [Q_W-1:0] o_wolfe_min,
    output logic signed [Q_W-1:0] o_bound_max
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FOLD = 3'b100
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic                  r_skip;
    logic                  r_last;
    logic signed [Q_W-1:0] r_q;
    logic signed [Q_W-1:0] r_min;
    logic signed [Q_W-1:0] r_wolfe;
    logic signed [Q_W-1:0] r_max;
    logic signed [Q_W-1:0] n_min;
    logic signed [Q_W-1:0] n_wolfe;
    logic signed [Q_W-1:0] n_max;
    logic signed [Q_W-1:0] r_out_min;
    logic signed [Q_W-1:0] r_out_wolfe;
    logic signed [Q_W-1:0] r_out_max;
    logic                  r_out_vld;

    logic                  div_start;
    logic                  div_done;
    logic signed [Q_W-1:0] div_quot;
    logic                  out_free;
    logic                  fold_go;

    assign out_free  = !r_out_vld || i_ready;
    assign o_pop     = (r_state == ST_IDLE) && i_job_valid;
    assign div_start = o_pop && !i_job.skip;
    assign fold_go   = (r_state == ST_FOLD) && (!r_last || out_free);

    bsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_diff  (i_job.diff),
        .i_dir   (i_job.dir),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // The positive-phase minimum looks at the least value after this ratio.
    always_comb begin
        n_min   = r_min;
        n_wolfe = r_wolfe;
        n_max   = r_max;
        if (!r_skip) begin
            if (r_q < r_min) begin
                n_min = r_q;
            end
            if (n_min > 0 && r_q < r_wolfe) begin
                n_wolfe = r_q;
            end
            if (r_q > r_max) begin
                n_max = r_q;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = i_job.skip ? ST_FOLD : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (fold_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_min     <= Q_MAX;
            r_wolfe   <= Q_MAX;
            r_max     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= (fold_go && r_last) || (r_out_vld && !i_ready);
            if (fold_go) begin
                if (r_last) begin
                    r_min     <= Q_MAX;
                    r_wolfe   <= Q_MAX;
                    r_max     <= '0;
                end else begin
                    r_min   <= n_min;
                    r_wolfe <= n_wolfe;
                    r_max   <= n_max;
                end
            end
        end
        if (o_pop) begin
            r_skip <= i_job.skip;
            r_last <= i_job.last;
        end
        if (r_state == ST_DIV && div_done) begin
            r_q <= div_quot;
        end
        if (fold_go && r_last) begin
            r_out_min   <= n_min;
            r_out_wolfe <= n_wolfe;
            r_out_max   <= n_max;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_bound_min = r_out_min;
    assign o_wolfe_min = r_out_wolfe;
    assign o_bound_max = r_out_max;

endmodule

FILE: rtl/bound_step_ratio_test.sv
// ----------------------------------------------------------------------------
// bound_step_ratio_test
// Streaming ratio test of a step direction against per-element bounds.
// ----------------------------------------------------------------------------
// The slave stream carries one vector element per word: position, lower and
// upper bound and step direction, all signed fixed point. tlast marks the
// final element. Each element with a nonzero direction yields the ratio of
// its distance to the bound it heads for over the direction, saturated to
// the fixed-point range. After the last element the master stream carries
// one word with the least ratio, the least ratio taken while the running
// least stayed positive, and the greatest ratio; the running values then
// return to their start values.
// Each element with a nonzero direction occupies the bit-serial divider,
// which loads, forms one quotient bit per cycle and finishes; the back end
// then folds its ratio. A zero direction skips the divider. An input
// register and a two-word queue let the slave side run ahead of the
// divider. A result passes the input register, the queue, the back end and
// its output register. While the receiver stalls, the result word holds
// and the back end waits before folding the next last word. Reset empties
// the queue and restores the running values; nothing else needs clearing.
// ----------------------------------------------------------------------------
module bound_step_ratio_test
    import bsr_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // position [31:0], lower_bound [63:32], upper_bound [95:64],
    // step_dir [127:96]
    input  logic [4*Q_W-1:0] s_axis_tdata,
    input  logic           s_axis_tlast,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // bound_min [31:0], wolfe_min [63:32], bound_max [95:64]
    output logic [3*Q_W-1:0] m_axis_tdata
);

    logic                  front_vld;
    t_job                  front_job;
    logic                  q_full;
    logic                  q_empty;
    t_job                  q_job;
    logic                  pop;
    logic signed [Q_W-1:0] bound_min;
    logic signed [Q_W-1:0] wolfe_min;
    logic signed [Q_W-1:0] bound_max;

    bsr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_position    (s_axis_tdata[Q_W-1:0]),
        .i_lower_bound (s_axis_tdata[2*Q_W-1:Q_W]),
        .i_upper_bound (s_axis_tdata[3*Q_W-1:2*Q_W]),
        .i_step_dir    (s_axis_tdata[4*Q_W-1:3*Q_W]),
        .i_last        (s_axis_tlast),
        .o_job_valid   (front_vld),
        .i_job_ready   (!q_full),
        .o_job         (front_job)
    );

    bsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_vld),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    bsr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job       (q_job),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_bound_min (bound_min),
        .o_wolfe_min (wolfe_min),
        .o_bound_max (bound_max)
    );

    assign m_axis_tdata = {bound_max, wolfe_min, bound_min};

endmodule

FILE: rtl/bsr_chk.sv
// ----------------------------------------------------------------------------
// bsr_chk
// Port-level checks of the bound step ratio test block, bound to its top.
// ----------------------------------------------------------------------------
module bsr_chk
    import bsr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [4*Q_W-1:0] s_axis_tdata,
    input  logic             s_axis_tlast,
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [3*Q_W-1:0] m_axis_tdata
);

    logic signed [Q_W-1:0] c_min;
    logic signed [Q_W-1:0] c_wolfe;
    logic signed [Q_W-1:0] c_max;

    assign c_min   = m_axis_tdata[Q_W-1:0];
    assign c_wolfe = m_axis_tdata[2*Q_W-1:Q_W];
    assign c_max   = m_axis_tdata[3*Q_W-1:2*Q_W];

    // A stalled result word keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // The greatest ratio starts at zero and so is never negative.
    a_max_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !c_max[Q_W-1])
        else $error("greatest ratio is negative");

    // The positive-phase minimum is taken from the same ratios.
    a_wolfe_ge_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> c_wolfe >= c_min)
        else $error("positive-phase minimum below least ratio");

    // With a positive least ratio every ratio was positive, so both agree.
    a_wolfe_eq_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && c_min > 0 |-> c_wolfe == c_min)
        else $error("positive-phase minimum differs from positive least ratio");

endmodule

bind bound_step_ratio_test bsr_chk u_bsr_chk (.*);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming bound step ratio test.
// ----------------------------------------------------------------------------
// Vector elements go in on the slave stream, and a predictor folds each
// accepted word into its own running least, positive-phase least and
// greatest ratios. On every tlast it queues the expected result word. Each
// word from the master stream is compared field by field with the oldest
// queued result. Directed frames cover the empty vector, saturated
// quotients, both direction signs, zero directions and the cases where the
// running least is no longer positive. Random frames then follow, first
// with random gaps and stalls on both sides and then with none at all.
// ----------------------------------------------------------------------------
module testbench
    import bsr_pkg::*;
();

    localparam int CYCLE_LIMIT = 500000;
    // Several elements can sit in the input register, queue and divider.
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic signed [Q_W-1:0] pos;
        logic signed [Q_W-1:0] lower;
        logic signed [Q_W-1:0] upper;
        logic signed [Q_W-1:0] dir;
        logic                  last;
    } t_elem;

    typedef struct {
        logic signed [Q_W-1:0] bound_min;
        logic signed [Q_W-1:0] wolfe_min;
        logic signed [Q_W-1:0] bound_max;
    } t_ratio_sum;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // position, lower_bound, upper_bound, step_dir
    logic [4*Q_W-1:0]     s_axis_tdata;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // bound_min, wolfe_min, bound_max
    logic [3*Q_W-1:0]     m_axis_tdata;

    logic signed [Q_W-1:0] acc_min;
    logic signed [Q_W-1:0] acc_wolfe;
    logic signed [Q_W-1:0] acc_max;
    t_ratio_sum            exp_sums[$];
    t_ratio_sum            got_sum;
    t_ratio_sum            want_sum;
    int                    fail_cnt;
    int                    cycle_cnt;
    bit                    no_stall;

    bound_step_ratio_test dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // (diff * 2^FRAC_BITS) / dir, truncated toward zero and saturated.
    function automatic logic signed [Q_W-1:0] step_ratio(input longint diff,
                                                         input longint dir);
        longint unsigned nmag;
        longint unsigned dmag;
        longint unsigned quo;
        bit              neg;
        neg  = (diff < 0) != (dir < 0);
        nmag = (diff < 0) ? -diff : diff;
        dmag = (dir < 0) ? -dir : dir;
        quo  = (nmag << FRAC_BITS) / dmag;
        if (neg) begin
            if (quo >= 64'h8000_0000)
                return Q_MIN;
            return Q_W'(-longint'(quo));
        end
        if (quo > 64'h7FFF_FFFF)
            return Q_MAX;
        return Q_W'(quo);
    endfunction

    function automatic void clear_ratios();
        acc_min   = Q_MAX;
        acc_wolfe = Q_MAX;
        acc_max   = '0;
    endfunction

    function automatic void fold_ratio(input t_elem e);
        logic signed [Q_W-1:0] q;
        t_ratio_sum            s;
        if (e.dir != 0) begin
            q = step_ratio((e.dir > 0) ? longint'(e.upper) - longint'(e.pos)
                                       : longint'(e.lower) - longint'(e.pos),
                           longint'(e.dir));
            if (q < acc_min)
                acc_min = q;
            if (acc_min > 0 && q < acc_wolfe)
                acc_wolfe = q;
            if (q > acc_max)
                acc_max = q;
        end
        if (e.last) begin
            s.bound_min = acc_min;
            s.wolfe_min = acc_wolfe;
            s.bound_max = acc_max;
            exp_sums.push_back(s);
            clear_ratios();
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the word
    // was taken, with tvalid still high so the next word can follow at once.
    task automatic send_elem(input t_elem e);
        while (!no_stall && $urandom_range(0, 99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {e.dir, e.upper, e.lower, e.pos};
        s_axis_tlast  <= e.last;
        do @(posedge i_clk); while (!s_axis_tready);
        fold_ratio(e);
        @(negedge i_clk);
    endtask

    task automatic send_fields(input logic signed [Q_W-1:0] pos, lower, upper,
                               dir, input logic last);
        t_elem e;
        e.pos   = pos;
        e.lower = lower;
        e.upper = upper;
        e.dir   = dir;
        e.last  = last;
        send_elem(e);
    endtask

    function automatic logic signed [Q_W-1:0] noise_word();
        case ($urandom_range(0, 5))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return '0;
            3:       return $urandom_range(0, 1 << 20) - (1 << 19);
            default: return $urandom;
        endcase
    endfunction

    // Mostly feasible elements (position inside its bounds), some noise.
    function automatic t_elem random_elem(input logic last);
        t_elem e;
        int    kind;
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            e.pos   = $urandom_range(0, 1 << 25) - (1 << 24);
            e.lower = e.pos - $urandom_range(0, 1 << 22);
            e.upper = e.pos + $urandom_range(0, 1 << 22);
            e.dir   = $urandom_range(1, 1 << 18);
            if ($urandom_range(0, 1))
                e.dir = -e.dir;
        end else begin
            e.pos   = (kind == 6) ? $urandom : noise_word();
            e.lower = (kind == 6) ? $urandom : noise_word();
            e.upper = (kind == 6) ? $urandom : noise_word();
            e.dir   = (kind == 6) ? $urandom : noise_word();
        end
        if ($urandom_range(0, 9) == 0)
            e.dir = '0;
        e.last = last;
        return e;
    endfunction

    task automatic send_random_frames(input int n_items);
        int sent;
        int frame_len;
        int k;
        sent = 0;
        while (sent < n_items) begin
            frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 8);
            for (k = 0; k < frame_len && sent < n_items; k++) begin
                send_elem(random_elem(k == frame_len - 1 || sent == n_items - 1));
                sent++;
            end
        end
    endtask

    task automatic test_empty_vector();
        send_fields(0, 0, 0, 0, 1'b1);
        send_fields(Q_MAX, Q_MIN, Q_MAX, 0, 1'b1);
    endtask

    task automatic test_saturation();
        send_fields(Q_MIN, 0, Q_MAX, 1, 1'b0);
        send_fields(Q_MAX, Q_MIN, 0, -1, 1'b0);
        send_fields(Q_MAX, 0, Q_MIN, 1, 1'b0);
        send_fields(0, 0, Q_MAX, Q_MAX, 1'b0);
        send_fields(0, Q_MIN, 0, Q_MIN, 1'b1);
    endtask

    task automatic test_sign_cases();
        // Positive-phase least freezes once the running least goes negative.
        send_fields(0, -32'sh1_0000, 32'sh2_0000, 32'sh1_0000, 1'b0);
        send_fields(32'sh5_0000, 0, 0, 0, 1'b0);
        send_fields(0, 0, 32'sh0_8000, 32'sh1_0000, 1'b0);
        send_fields(32'sh1_0000, 0, 0, 32'sh1_0000, 1'b0);
        send_fields(0, 0, 32'sh0_4000, 32'sh1_0000, 1'b0);
        send_fields(32'sh3_0000, 32'sh3_0000, 32'sh4_0000, -32'sh1_0000, 1'b1);
        // A zero ratio first keeps the positive-phase least at its start value.
        send_fields(32'sh2_0000, 0, 32'sh2_0000, 32'sh1_0000, 1'b0);
        send_fields(0, -32'sh1_0000, 32'sh3_0000, 32'sh1_0000, 1'b0);
        send_fields(0, 0, 0, 0, 1'b1);
        // Negative direction and truncation toward zero on both signs.
        send_fields(32'sh1_0000, -32'sh1_0000, 0, -32'sh0_8000, 1'b0);
        send_fields(0, 0, 1, 3, 1'b0);
        send_fields(0, 0, -1, 3, 1'b0);
        send_fields(0, 1, 0, -3, 1'b1);
    endtask

    task automatic test_random_with_gaps();
        no_stall = 1'b0;
        send_random_frames(480);
    endtask

    task automatic test_random_steady();
        no_stall = 1'b1;
        send_random_frames(250);
        no_stall = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [Q_W-1:0] want,
                               input logic [Q_W-1:0] got);
        if (want !== got) begin
            $display("%t: %s mismatch, expected %h actual %h", $time, name,
                     want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_sum.bound_min = m_axis_tdata[Q_W-1:0];
            got_sum.wolfe_min = m_axis_tdata[2*Q_W-1:Q_W];
            got_sum.bound_max = m_axis_tdata[3*Q_W-1:2*Q_W];
            if (exp_sums.size() == 0) begin
                $display("%t: unexpected result word, expected none actual %h",
                         $time, m_axis_tdata);
                fail_cnt++;
            end else begin
                want_sum = exp_sums.pop_front();
                check_field("bound_min", want_sum.bound_min, got_sum.bound_min);
                check_field("wolfe_min", want_sum.wolfe_min, got_sum.wolfe_min);
                check_field("bound_max", want_sum.bound_max, got_sum.bound_max);
            end
        end
    end

    always @(negedge i_clk)
        m_axis_tready <= no_stall || ($urandom_range(0, 99) >= 36);

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%t: timeout with %0d results outstanding", $time,
                     exp_sums.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        no_stall      = 1'b0;
        fail_cnt      = 0;
        cycle_cnt     = 0;
        clear_ratios();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_vector();
        test_saturation();
        test_sign_cases();
        test_random_with_gaps();
        test_random_steady();

        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (exp_sums.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
